// ===== rtl/lats_pkg.sv =====
// ----------------------------------------------------------------------------
// Life automaton package
// Beat types, opcodes and the birth and survival rule shared by the grid
// datapath and its control.
// ----------------------------------------------------------------------------
package lats_pkg;

  localparam int LATS_GRID_WIDTH  = 64;
  localparam int LATS_GRID_HEIGHT = 64;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] column;
    logic [5:0] row;
    logic       alive;
  } lats_in_t;

  typedef struct packed {
    logic [63:0] row_cells;
    logic [31:0] generation;
  } lats_out_t;

  typedef struct packed {
    logic above;
    logic mid;
    logic below;
  } lats_nbr_t;

  function automatic logic lats_rule(input logic self_live, input logic [3:0] count);
    logic live;
    if (self_live) begin
      live = (count == SURVIVE_LOW) || (count == BIRTH_COUNT);
    end else begin
      live = (count == BIRTH_COUNT);
    end
    return live;
  endfunction

endpackage

// ===== rtl/lats_cell.sv =====
// ----------------------------------------------------------------------------
// Life automaton column cell
// Holds the rows above and at the current position for one column and
// computes that column's next state from its own and its neighbors' bits.
// ----------------------------------------------------------------------------
module lats_cell import lats_pkg::*; (
  input  logic      clk_i,
  input  logic      shift_i,
  input  logic      below_i,
  input  lats_nbr_t left_i,
  input  lats_nbr_t right_i,
  output lats_nbr_t own_o,
  output logic      next_o
);

  logic       above_q;
  logic       mid_q;
  logic [7:0] nb;
  logic [3:0] count;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      above_q <= mid_q;
      mid_q   <= below_i;
    end
  end

  assign own_o.above = above_q;
  assign own_o.mid   = mid_q;
  assign own_o.below = below_i;

  assign nb = {left_i.above, left_i.mid, left_i.below, above_q,
               below_i, right_i.above, right_i.mid, right_i.below};

  always_comb begin
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + 4'(nb[k]);
    end
  end

  assign next_o = lats_rule(mid_q, count);

endmodule

// ===== rtl/lats_row.sv =====
// ----------------------------------------------------------------------------
// Life automaton cell row
// One cell per column, each joined to its left and right neighbor with
// wrap-around at both ends of the row.
// ----------------------------------------------------------------------------
module lats_row import lats_pkg::*; #(
  parameter int GRID_WIDTH = LATS_GRID_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic [GRID_WIDTH-1:0] below_i,
  output logic [GRID_WIDTH-1:0] next_o
);

  lats_nbr_t own [GRID_WIDTH];

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
    lats_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .below_i (below_i[c]),
      .left_i  (own[(c + GRID_WIDTH - 1) % GRID_WIDTH]),
      .right_i (own[(c + 1) % GRID_WIDTH]),
      .own_o   (own[c]),
      .next_o  (next_o[c])
    );
  end

endmodule

// ===== rtl/life_automaton_torus_step.sv =====
// ----------------------------------------------------------------------------
// Toroidal life automaton
// Grid of one-bit cells under the B3/S23 rule with a 32-bit generation count.
// ----------------------------------------------------------------------------
// Each input beat carries an opcode: set cell, clear grid, advance one
// generation, or read row. Every input beat yields exactly one output beat
// with the row read (zero for other opcodes) and the generation count.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. One item is in work at a time; the input is stalled from
// acceptance until the result sits in the output register, and the next
// item may be accepted while that result still waits to be taken.
// Set cell and read row read the addressed row, then update or capture it;
// clear writes zero to every row. Advance streams the rows through the
// single read port of the row memory, one row a cycle, into a row of
// column cells that produce one new row per cycle.
// After reset the row memory is cleared, one row a cycle, while the input
// is stalled. A stalled output holds its beat, and a finished result then
// waits in the block until the output register frees.
// ----------------------------------------------------------------------------
module life_automaton_torus_step import lats_pkg::*; #(
  parameter int GRID_WIDTH  = LATS_GRID_WIDTH,
  parameter int GRID_HEIGHT = LATS_GRID_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lats_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lats_out_t out_data_o
);

  localparam int AW = $clog2(GRID_HEIGHT);
  localparam int CW = $clog2(GRID_HEIGHT + 3);

  localparam logic [CW-1:0] ADV_LAST  = CW'(GRID_HEIGHT + 2);
  localparam logic [CW-1:0] ADV_READS = CW'(GRID_HEIGHT);
  localparam logic [CW-1:0] CLR_LAST  = CW'(GRID_HEIGHT - 1);
  localparam logic [AW-1:0] ROW_LAST  = AW'(GRID_HEIGHT - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SETW = 3'd1;
  localparam logic [2:0] ST_RDW  = 3'd2;
  localparam logic [2:0] ST_ADV  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [31:0]           gen_q, gen_d;
  logic [63:0]           res_q, res_d;
  logic                  reply_q, reply_d;
  logic [AW-1:0]         addr_q;
  logic [5:0]            col_q;
  logic                  alive_q;
  logic [GRID_WIDTH-1:0] first_q;
  logic                  out_valid_q;
  lats_out_t             out_data_q;

  logic [GRID_WIDTH-1:0] mem_q [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rdata_q;

  logic                  accept;
  logic                  row_ok;
  logic                  col_ok;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [GRID_WIDTH-1:0] wdata;
  logic [GRID_WIDTH-1:0] bit_mask;
  logic [GRID_WIDTH-1:0] below;
  logic [GRID_WIDTH-1:0] next_row;
  logic                  shift;
  logic                  out_load;
  logic [CW-1:0]         rd_idx;
  logic [CW-1:0]         wr_idx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign row_ok     = 32'(in_data_i.row) < 32'(GRID_HEIGHT);
  assign col_ok     = 32'(in_data_i.column) < 32'(GRID_WIDTH);
  assign bit_mask   = GRID_WIDTH'(1) << col_q;
  assign rd_idx     = cnt_q - CW'(1);
  assign wr_idx     = cnt_q - CW'(3);

  lats_row #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_row (
    .clk_i   (clk_i),
    .shift_i (shift),
    .below_i (below),
    .next_o  (next_row)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    gen_d    = gen_q;
    res_d    = res_q;
    reply_d  = reply_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = addr_q;
    raddr    = addr_q;
    wdata    = '0;
    shift    = 1'b0;
    below    = rdata_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (in_data_i.opcode)
            OP_SET: begin
              if (row_ok && col_ok) begin
                mem_re  = 1'b1;
                raddr   = AW'(in_data_i.row);
                state_d = ST_SETW;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_CLEAR: begin
              gen_d   = '0;
              cnt_d   = '0;
              reply_d = 1'b1;
              state_d = ST_CLR;
            end
            OP_ADVANCE: begin
              cnt_d   = '0;
              state_d = ST_ADV;
            end
            default: begin
              if (row_ok) begin
                mem_re  = 1'b1;
                raddr   = AW'(in_data_i.row);
                state_d = ST_RDW;
              end else begin
                state_d = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_SETW: begin
        mem_we  = 1'b1;
        waddr   = addr_q;
        wdata   = alive_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
        state_d = ST_DONE;
      end
      ST_RDW: begin
        res_d   = 64'(rdata_q);
        state_d = ST_DONE;
      end
      ST_ADV: begin
        mem_re = (cnt_q <= ADV_READS);
        raddr  = (cnt_q == '0) ? ROW_LAST : rd_idx[AW-1:0];
        shift  = (cnt_q != '0);
        below  = (cnt_q == ADV_LAST) ? first_q : rdata_q;
        mem_we = (cnt_q >= CW'(3));
        waddr  = wr_idx[AW-1:0];
        wdata  = next_row;
        if (cnt_q == ADV_LAST) begin
          gen_d   = gen_q + 32'd1;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        waddr  = cnt_q[AW-1:0];
        wdata  = '0;
        if (cnt_q == CLR_LAST) begin
          state_d = reply_q ? ST_DONE : ST_IDLE;
          reply_d = 1'b0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      gen_q       <= '0;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      gen_q   <= gen_d;
      reply_q <= reply_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      addr_q  <= AW'(in_data_i.row);
      col_q   <= in_data_i.column;
      alive_q <= in_data_i.alive;
    end
    if (state_q == ST_ADV && cnt_q == CW'(2)) begin
      first_q <= rdata_q;
    end
    if (out_load) begin
      out_data_q.row_cells  <= res_q;
      out_data_q.generation <= gen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_adv_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV && cnt_q == ADV_LAST) |=> gen_q == $past(gen_q) + 32'd1)
    else $error("generation count did not step after advance");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("row memory written while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != ST_IDLE)
    else $error("accepted item left no work in flight");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> state_q == ST_DONE)
    else $error("finished result dropped while output stalled");

endmodule
